// ===== rtl/note_token_parser_macros.svh =====
// Assertion helpers for the note token parser.
`ifndef NOTE_TOKEN_PARSER_MACROS_SVH
`define NOTE_TOKEN_PARSER_MACROS_SVH

// cond must never hold
`define NTP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ntp: forbidden condition seen");

// a implies c in the same cycle
`define NTP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("ntp: implication failed");

// a implies c in the next cycle
`define NTP_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("ntp: next-cycle implication failed");

`endif

// ===== rtl/ntp_pkg.sv =====
`default_nettype none
package ntp_pkg;

  localparam int MIDI_W = 7;
  localparam int DUR_W  = 19;
  localparam int RATE_W = 21;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REST = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HIT  = 2'd3;

  localparam logic [DUR_W-1:0]  ONE_BEAT_Q16   = 19'd65536;
  localparam logic [DUR_W-1:0]  FOUR_BEATS_Q16 = 19'd262144;
  localparam logic [21:0]       DIVISOR_CAP    = 22'd262145;
  localparam logic [13:0]       NUMBER_CAP     = 14'd999;
  localparam logic [RATE_W-1:0] RATE_UNITY     = 21'd65536;

  localparam int CFG_KEY   = 0;
  localparam int CFG_SCALE = 1;

  // controller to datapath commands
  typedef struct packed {
    logic take;      // char item accepted this cycle
    logic eval;      // close token, latch result, start divider
    logic load_out;  // move result into output register
  } ntp_cmd_t;

  // round(2^(k/12) * 2^30)
  function automatic logic [30:0] octave_q30(input logic [3:0] k);
    logic [30:0] v;
    unique case (k)
      4'd0:    v = 31'd1073741824;
      4'd1:    v = 31'd1137589835;
      4'd2:    v = 31'd1205234447;
      4'd3:    v = 31'd1276901417;
      4'd4:    v = 31'd1352829926;
      4'd5:    v = 31'd1433273380;
      4'd6:    v = 31'd1518500250;
      4'd7:    v = 31'd1608794974;
      4'd8:    v = 31'd1704458901;
      4'd9:    v = 31'd1805811301;
      4'd10:   v = 31'd1913190429;
      4'd11:   v = 31'd2026954652;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] degree_offset(input logic minor, input logic [2:0] idx);
    logic [3:0] v;
    unique case (idx)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd2;
      3'd2:    v = minor ? 4'd3 : 4'd4;
      3'd3:    v = 4'd5;
      3'd4:    v = 4'd7;
      3'd5:    v = minor ? 4'd8 : 4'd9;
      3'd6:    v = minor ? 4'd10 : 4'd11;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // 2^((m-69)/12) in Q5.16, round half up
  function automatic logic [RATE_W-1:0] rate_for(input logic [MIDI_W-1:0] m);
    logic [7:0]  t;
    logic [13:0] p;
    logic [3:0]  o;
    logic [7:0]  o12;
    logic [3:0]  k;
    logic [4:0]  s;
    logic [31:0] x;
    logic [31:0] r;
    t   = {1'b0, m} + 8'd3;
    p   = 14'(t) * 14'd43;   // t/12 exact for t <= 130
    o   = p[12:9];
    o12 = {4'b0, o} * 8'd12;
    k   = 4'(t - o12);
    s   = 5'd20 - {1'b0, o};
    x   = {1'b0, octave_q30(k)};
    r   = (x + (32'd1 << (s - 5'd1))) >> s;
    return r[RATE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ntp_div.sv =====
`default_nettype none
module ntp_div
  import ntp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DUR_W-1:0] den,
  output logic                  busy,
  output logic [DUR_W-1:0]      quo
);

  // restoring divide of four beats by den, one quotient bit a cycle
  logic             busy_r, busy_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [DUR_W-1:0] rem_r;
  logic [DUR_W-1:0] quo_r, den_r;
  logic [DUR_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, quo_r[DUR_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(DUR_W - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // for a nonzero den the remainder stays below den, so it fits DUR_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= FOUR_BEATS_Q16;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DUR_W'(rem_sh - {1'b0, den_r}) : rem_sh[DUR_W-1:0];
      quo_r <= {quo_r[DUR_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/ntp_ctrl.sv =====
`default_nettype none
module ntp_ctrl
  import ntp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tlast,
  input  wire logic out_tready,
  input  wire logic div_busy,
  output logic      in_tready,
  output logic      out_tvalid,
  output ntp_cmd_t  cmd
);

  typedef enum logic [1:0] {S_RUN, S_EVAL, S_DIV, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.take      = (state_r == S_RUN) && in_tvalid;
    unique case (state_r)
      S_RUN:  if (in_tvalid && in_tlast) state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV:  if (!div_busy) state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_RUN);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/ntp_dpath.sv =====
`default_nettype none
module ntp_dpath
  import ntp_pkg::*;
#(
  parameter int MAX_TOKEN_CHARS = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ntp_cmd_t          cmd,
  input  wire logic [7:0]        ch,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [3:0]        cfg_data,
  input  wire logic [DUR_W-1:0]  div_quo,
  output logic [DUR_W-1:0]       div_den,
  output logic [KIND_W-1:0]      out_kind,
  output logic [MIDI_W-1:0]      out_midi,
  output logic                   out_clamped,
  output logic                   out_malformed,
  output logic [DUR_W-1:0]       out_duration,
  output logic [RATE_W-1:0]      out_rate
);

  localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int SW = CW + 1;
  localparam int DW = SW + 6;

  typedef enum logic [3:0] {
    PH_C0, PH_C1, PH_OCT0, PH_WS, PH_SGN, PH_DIG, PH_LOCK,
    PH_DEG_NUM, PH_DEG_SH, PH_FAIL, PH_NONE
  } phase_t;

  typedef enum logic [2:0] {
    CL_HIT, CL_ONE, CL_TILDE, CL_DLET, CL_KEY, CL_SIGN, CL_DIGIT, CL_LETTER
  } cls_t;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_SHARP = 2'd1;
  localparam logic [1:0] ACC_FLAT  = 2'd2;

  typedef enum logic [1:0] {DS_WS, DS_SGN, DS_DIG, DS_END} dstate_t;

  // config
  logic [3:0] key_r;
  logic       minor_r;

  // token parse state
  phase_t          phase_r, phase_nxt;
  cls_t            cls_r, cls_nxt;
  logic [3:0]      base_r, base_nxt;
  logic [1:0]      acc_r, acc_nxt;
  logic [9:0]      num_r, num_nxt;
  logic            neg_r, neg_nxt;
  logic signed [SW-1:0] shift_r, shift_nxt;
  logic [DUR_W-1:0] den_r, den_nxt;
  dstate_t         dst_r, dst_nxt;
  logic            dneg_r, dneg_nxt;
  logic            slash_r, slash_nxt;
  logic            closed_r, closed_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  // latched result
  logic [KIND_W-1:0] res_kind_r;
  logic [MIDI_W-1:0] res_midi_r;
  logic              res_clamp_r, res_malf_r, res_use_div_r, res_zero_r;
  logic [RATE_W-1:0] rate_r;

  // character decode
  logic       is_dig, is_sp, is_sign, eff;
  logic [3:0] dval;
  logic [7:0] lc;
  logic       let_ok;
  logic [3:0] let_base;
  logic [13:0] nm;
  logic [9:0]  num_sat;
  logic [21:0] dm;
  logic [DUR_W-1:0] den_sat;

  assign is_dig  = (ch >= "0") && (ch <= "9");
  assign dval    = 4'(ch - "0");
  assign is_sp   = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
  assign is_sign = (ch == "+") || (ch == "-");
  assign lc      = ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
  assign eff     = cmd.take && !closed_r && (ch != 8'd0) &&
                   (count_r < CW'(MAX_TOKEN_CHARS));

  assign nm      = 14'(num_r) * 14'd10 + 14'(dval);
  assign num_sat = (nm > NUMBER_CAP) ? NUMBER_CAP[9:0] : nm[9:0];
  assign dm      = 22'(den_r) * 22'd10 + 22'(dval);
  assign den_sat = (dm > DIVISOR_CAP) ? DIVISOR_CAP[DUR_W-1:0] : dm[DUR_W-1:0];

  always_comb begin
    let_ok   = 1'b1;
    let_base = 4'd0;
    unique case (lc)
      "c":     let_base = 4'd0;
      "d":     let_base = 4'd2;
      "e":     let_base = 4'd4;
      "f":     let_base = 4'd5;
      "g":     let_base = 4'd7;
      "a":     let_base = 4'd9;
      "b":     let_base = 4'd11;
      default: let_ok   = 1'b0;
    endcase
  end

  // per-character state update
  always_comb begin
    phase_nxt  = phase_r;
    cls_nxt    = cls_r;
    base_nxt   = base_r;
    acc_nxt    = acc_r;
    num_nxt    = num_r;
    neg_nxt    = neg_r;
    shift_nxt  = shift_r;
    den_nxt    = den_r;
    dst_nxt    = dst_r;
    dneg_nxt   = dneg_r;
    slash_nxt  = slash_r;
    closed_nxt = closed_r;
    count_nxt  = count_r;

    if (cmd.take && !closed_r && (ch == 8'd0)) closed_nxt = 1'b1;
    if (eff) count_nxt = count_r + CW'(1);

    if (eff && !slash_r && (ch == "/")) begin
      slash_nxt = 1'b1;   // pitch part frozen, duration part follows
    end else if (eff && slash_r) begin
      unique case (dst_r)
        DS_WS: begin
          priority if (is_sp) dst_nxt = DS_WS;
          else if (is_sign) begin
            dneg_nxt = (ch == "-");
            dst_nxt  = DS_SGN;
          end else if (is_dig) begin
            den_nxt = DUR_W'(dval);
            dst_nxt = DS_DIG;
          end else dst_nxt = DS_END;
        end
        DS_SGN: begin
          if (is_dig) begin
            den_nxt = DUR_W'(dval);
            dst_nxt = DS_DIG;
          end else dst_nxt = DS_END;
        end
        DS_DIG: begin
          if (is_dig) den_nxt = den_sat;
          else dst_nxt = DS_END;
        end
        default: dst_nxt = DS_END;
      endcase
    end else if (eff) begin
      unique case (phase_r)
        PH_C0: begin
          priority if ((ch == "x") || (ch == "X")) begin
            cls_nxt = CL_HIT;   phase_nxt = PH_C1;
          end else if (ch == "1") begin
            cls_nxt = CL_ONE;   num_nxt = 10'd1; phase_nxt = PH_C1;
          end else if (ch == "~") begin
            cls_nxt = CL_TILDE; phase_nxt = PH_C1;
          end else if (lc == "d") begin
            cls_nxt = CL_DLET;  base_nxt = 4'd2; phase_nxt = PH_C1;
          end else if (lc == "k") begin
            cls_nxt = CL_KEY;   phase_nxt = PH_WS;
          end else if (is_sign) begin
            cls_nxt = CL_SIGN;  neg_nxt = (ch == "-"); phase_nxt = PH_C1;
          end else if (is_dig) begin
            cls_nxt = CL_DIGIT; num_nxt = 10'(dval); phase_nxt = PH_DIG;
          end else if (let_ok) begin
            cls_nxt = CL_LETTER; base_nxt = let_base; phase_nxt = PH_C1;
          end else phase_nxt = PH_NONE;
        end
        PH_C1: begin
          unique case (cls_r)
            CL_HIT, CL_TILDE: phase_nxt = PH_NONE;
            CL_ONE: begin
              priority if (is_dig) begin
                num_nxt = num_sat; phase_nxt = PH_DIG;
              end else if (is_sp) phase_nxt = PH_LOCK;
              else phase_nxt = PH_FAIL;
            end
            CL_SIGN: begin
              if (is_dig) begin
                num_nxt = 10'(dval); phase_nxt = PH_DIG;
              end else phase_nxt = PH_NONE;
            end
            CL_DLET, CL_LETTER: begin
              // 'd' with a digit is always a scale degree
              priority if (is_dig && (cls_r == CL_DLET)) begin
                num_nxt = 10'(dval); phase_nxt = PH_DEG_NUM;
              end else if (ch == "#") begin
                acc_nxt = ACC_SHARP; phase_nxt = PH_OCT0;
              end else if (lc == "b") begin
                acc_nxt = ACC_FLAT;  phase_nxt = PH_OCT0;
              end else if (is_dig) begin
                num_nxt = 10'(dval); phase_nxt = PH_DIG;
              end else phase_nxt = PH_FAIL;
            end
            default: phase_nxt = PH_FAIL;
          endcase
        end
        PH_OCT0, PH_SGN: begin
          if (is_dig) begin
            num_nxt = 10'(dval); phase_nxt = PH_DIG;
          end else phase_nxt = PH_FAIL;
        end
        PH_WS: begin
          priority if (is_sp) phase_nxt = PH_WS;
          else if (is_sign) begin
            neg_nxt = (ch == "-"); phase_nxt = PH_SGN;
          end else if (is_dig) begin
            num_nxt = 10'(dval); phase_nxt = PH_DIG;
          end else phase_nxt = PH_FAIL;
        end
        PH_DIG: begin
          priority if (is_dig) num_nxt = num_sat;
          else if (is_sp) phase_nxt = PH_LOCK;
          else phase_nxt = PH_FAIL;
        end
        PH_DEG_NUM, PH_DEG_SH: begin
          priority if (is_dig && (phase_r == PH_DEG_NUM)) num_nxt = num_sat;
          else if (ch == "^") begin
            shift_nxt = shift_r + SW'(1); phase_nxt = PH_DEG_SH;
          end else if (ch == "_") begin
            shift_nxt = shift_r - SW'(1); phase_nxt = PH_DEG_SH;
          end else phase_nxt = PH_FAIL;
        end
        default: phase_nxt = phase_r;   // locked, failed or none
      endcase
    end

    if (cmd.eval) begin
      phase_nxt  = PH_C0;
      cls_nxt    = CL_HIT;
      base_nxt   = 4'd0;
      acc_nxt    = ACC_NONE;
      num_nxt    = 10'd0;
      neg_nxt    = 1'b0;
      shift_nxt  = '0;
      den_nxt    = '0;
      dst_nxt    = DS_WS;
      dneg_nxt   = 1'b0;
      slash_nxt  = 1'b0;
      closed_nxt = 1'b0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= 4'd0;
      minor_r  <= 1'b0;
      phase_r  <= PH_C0;
      cls_r    <= CL_HIT;
      base_r   <= 4'd0;
      acc_r    <= ACC_NONE;
      num_r    <= 10'd0;
      neg_r    <= 1'b0;
      shift_r  <= '0;
      den_r    <= '0;
      dst_r    <= DS_WS;
      dneg_r   <= 1'b0;
      slash_r  <= 1'b0;
      closed_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (cfg_valid && (cfg_index == 1'(CFG_KEY)))   key_r   <= cfg_data;
      if (cfg_valid && (cfg_index == 1'(CFG_SCALE))) minor_r <= cfg_data[0];
      phase_r  <= phase_nxt;
      cls_r    <= cls_nxt;
      base_r   <= base_nxt;
      acc_r    <= acc_nxt;
      num_r    <= num_nxt;
      neg_r    <= neg_nxt;
      shift_r  <= shift_nxt;
      den_r    <= den_nxt;
      dst_r    <= dst_nxt;
      dneg_r   <= dneg_nxt;
      slash_r  <= slash_nxt;
      closed_r <= closed_nxt;
      count_r  <= count_nxt;
    end
  end

  // end-of-token evaluation
  logic [6:0] key_midi, num_midi, let_midi, deg_midi;
  logic       key_clamp, num_clamp, let_clamp, deg_clamp;
  logic [3:0] oct;
  logic [7:0] let_sum, deg_base;
  logic signed [DW-1:0] dsum;
  logic [KIND_W-1:0] e_kind;
  logic [6:0]  e_midi;
  logic        e_clamp, e_malf;

  always_comb begin
    // piano key, 1..88
    key_clamp = neg_r || (num_r == 10'd0) || (num_r > 10'd88);
    if (neg_r || (num_r == 10'd0)) key_midi = 7'd21;
    else if (num_r > 10'd88)       key_midi = 7'd108;
    else                           key_midi = 7'(num_r) + 7'd20;
    // MIDI number, 0..127
    if (neg_r) begin
      num_midi  = 7'd0;
      num_clamp = (num_r != 10'd0);
    end else if (num_r > 10'd127) begin
      num_midi  = 7'd127;
      num_clamp = 1'b1;
    end else begin
      num_midi  = 7'(num_r);
      num_clamp = 1'b0;
    end
    // letter name, octave 0..8
    let_clamp = (num_r > 10'd8);
    oct       = let_clamp ? 4'd8 : num_r[3:0];
    let_sum   = ({4'b0, oct} + 8'd1) * 8'd12 + {4'b0, base_r};
    if (acc_r == ACC_SHARP)     let_sum = let_sum + 8'd1;
    else if (acc_r == ACC_FLAT) let_sum = let_sum - 8'd1;
    let_midi  = let_sum[6:0];
    // scale degree
    deg_base  = 8'd60 + {4'b0, key_r} +
                {4'b0, degree_offset(minor_r, 3'(num_r - 10'd1))};
    dsum      = DW'(deg_base) + DW'(shift_r) * DW'(12);
    deg_clamp = (dsum < 0) || (dsum > 127);
    if (dsum < 0)        deg_midi = 7'd0;
    else if (dsum > 127) deg_midi = 7'd127;
    else                 deg_midi = dsum[6:0];

    e_kind  = KIND_REST;
    e_midi  = 7'd0;
    e_clamp = 1'b0;
    e_malf  = 1'b0;
    unique case (phase_r)
      PH_C0, PH_NONE: e_kind = KIND_NONE;
      PH_C1: begin
        unique case (cls_r)
          CL_HIT, CL_ONE: e_kind = KIND_HIT;
          CL_TILDE:       e_kind = KIND_REST;
          CL_SIGN:        e_kind = KIND_NONE;
          default:        e_malf = 1'b1;
        endcase
      end
      PH_DIG, PH_LOCK: begin
        e_kind = KIND_NOTE;
        unique case (cls_r)
          CL_KEY: begin
            e_midi = key_midi; e_clamp = key_clamp;
          end
          CL_DLET, CL_LETTER: begin
            e_midi = let_midi; e_clamp = let_clamp;
          end
          default: begin
            e_midi = num_midi; e_clamp = num_clamp;
          end
        endcase
      end
      PH_DEG_NUM, PH_DEG_SH: begin
        if ((num_r >= 10'd1) && (num_r <= 10'd7)) begin
          e_kind  = KIND_NOTE;
          e_midi  = deg_midi;
          e_clamp = deg_clamp;
        end else e_malf = 1'b1;
      end
      default: e_malf = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_kind_r    <= e_kind;
      res_midi_r    <= e_midi;
      res_clamp_r   <= e_clamp;
      res_malf_r    <= e_malf;
      res_zero_r    <= (e_kind == KIND_NONE);
      res_use_div_r <= slash_r && !dneg_r && (den_r != '0);
    end
    rate_r <= (res_kind_r == KIND_NOTE) ? rate_for(res_midi_r) : RATE_UNITY;
    if (cmd.load_out) begin
      out_kind      <= res_kind_r;
      out_midi      <= res_midi_r;
      out_clamped   <= res_clamp_r;
      out_malformed <= res_malf_r;
      out_rate      <= rate_r;
      if (res_zero_r)         out_duration <= '0;
      else if (res_use_div_r) out_duration <= div_quo;
      else                    out_duration <= ONE_BEAT_Q16;
    end
  end

  assign div_den = den_r;

endmodule
`default_nettype wire

// ===== rtl/note_token_parser.sv =====
// Note token parser. Characters of one token enter one per item on the in_
// stream; the item with in_tlast set closes the token and yields exactly one
// result on the out_ stream (kind in out_tuser, pitch, flags, duration and
// playback rate in out_tdata). Each character is parsed in the cycle it is
// accepted. Closing a token runs an evaluation state, a divider wait (19
// quotient steps of the bit-serial duration divider, then a check that it
// has gone idle) and a load of the output register, which makes the result
// valid. The input is held off during that tail. A finished result can wait
// in the output register while the next token streams in; the load of the
// next result stalls until that waiting item is taken. Characters beyond
// MAX_TOKEN_CHARS are dropped, and a zero character ends the token text.
// Config writes (key tonic, scale_minor) are taken at any cycle but are
// meant to happen while the block is idle.
`default_nettype none
`include "note_token_parser_macros.svh"
module note_token_parser
  import ntp_pkg::*;
#(
  parameter int MAX_TOKEN_CHARS = 63
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [6:0] note number, [7] clamped, [8] malformed,
                                       // [27:9] duration_q16, [48:28] rate_q16
  output logic [1:0]       out_tuser,  // [1:0] kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,  // 0 key tonic, 1 scale_minor
  input  wire logic [3:0]  cfg_data
);

  ntp_cmd_t          cmd;
  logic              div_busy;
  logic [DUR_W-1:0]  div_den, div_quo;
  logic [KIND_W-1:0] kind;
  logic [MIDI_W-1:0] midi;
  logic              clamped, malformed;
  logic [DUR_W-1:0]  duration;
  logic [RATE_W-1:0] rate;

  assign cfg_ready = 1'b1;

  ntp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .div_busy   (div_busy),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  ntp_dpath #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .ch            (in_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .div_quo       (div_quo),
    .div_den       (div_den),
    .out_kind      (kind),
    .out_midi      (midi),
    .out_clamped   (clamped),
    .out_malformed (malformed),
    .out_duration  (duration),
    .out_rate      (rate)
  );

  // divider is started by the close-token command
  ntp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.eval),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign out_tuser = kind;
  assign out_tdata = {7'd0, rate, duration, malformed, clamped, midi};

  // a waiting result is never overwritten
  `NTP_ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.load_out && out_tvalid && !out_tready)
  // no character is taken while the divider works
  `NTP_ASSERT_IMP(a_busy_blocks_in, clk, rst_n, div_busy, !in_tready)
  // the closing character is followed by evaluation
  `NTP_ASSERT_NEXT(a_last_evals, clk, rst_n, in_tvalid && in_tready && in_tlast, cmd.eval)

endmodule
`default_nettype wire

// ===== dv/ntp_checker.sv =====
`timescale 1ns / 1ps
// Watches the parser's channels, predicts each token's result and compares it.
module ntp_checker
  import ntp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output int          err_count,
  output int          pending,
  output int          tokens_checked,
  output int          notes_checked
);

  localparam int TOKEN_MAX = 63;
  localparam int NUM_SAT   = 999;
  localparam int DIV_SAT   = 262145;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [MIDI_W-1:0] midi;
    logic              clamped;
    logic              malformed;
    logic [DUR_W-1:0]  dur;
    logic [RATE_W-1:0] rate;
  } note_result_t;

  // 2^(k/12) in Q30
  localparam longint unsigned SEMI_Q30 [12] = '{
    1073741824, 1137589835, 1205234447, 1276901417, 1352829926, 1433273380,
    1518500250, 1608794974, 1704458901, 1805811301, 1913190429, 2026954652};

  logic [3:0]   key_tonic;
  logic         minor_mode;
  byte unsigned tok_buf [TOKEN_MAX];
  int           tok_len;
  bit           tok_closed;
  note_result_t expected_notes [$];
  int           errs, checked, notes, queued;

  assign err_count      = errs;
  assign pending        = queued;
  assign tokens_checked = checked;
  assign notes_checked  = notes;

  function automatic int char_at(int i, int n);
    if (i < n && i < TOKEN_MAX) return tok_buf[i];
    return 0;
  endfunction

  function automatic bit is_dig(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_ws(int c);
    return c == " " || (c >= 9 && c <= 13);
  endfunction

  // white space, sign, saturating digit run
  function automatic bit scan_num(input int n, input int pos, input int cap,
                                  output int mag, output bit neg, output int stop);
    int i;
    int v;
    bit ng;
    i = pos; v = 0; ng = 0;
    mag = 0; neg = 0; stop = pos;
    while (is_ws(char_at(i, n))) i++;
    if (char_at(i, n) == "+" || char_at(i, n) == "-") begin
      ng = char_at(i, n) == "-";
      i++;
    end
    if (!is_dig(char_at(i, n))) return 0;
    while (is_dig(char_at(i, n))) begin
      v = v * 10 + char_at(i, n) - "0";
      if (v > cap) v = cap;
      i++;
    end
    mag = v; neg = ng; stop = i;
    return 1;
  endfunction

  function automatic bit ends_ok(int n, int e);
    return char_at(e, n) == 0 || is_ws(char_at(e, n));
  endfunction

  function automatic logic [RATE_W-1:0] pitch_rate(int m);
    int t;
    int s;
    longint unsigned x;
    t = m + 3;
    s = 20 - t / 12;
    x = (SEMI_Q30[t % 12] + (64'd1 << (s - 1))) >> s;
    return x[RATE_W-1:0];
  endfunction

  function automatic note_result_t predict_note();
    note_result_t r;
    int n, p, i, c0, c1, midi, mag, e, v, deg, shift, base, acc, lc, offs;
    bit ok, clamp, neg, known;
    n = tok_len; p = n; ok = 0; clamp = 0; midi = 0;
    for (i = 0; i < n; i++)
      if (char_at(i, n) == "/") begin
        p = i;
        break;
      end
    c0 = char_at(0, p);
    c1 = char_at(1, p);
    r.kind = KIND_REST; r.midi = '0; r.clamped = 0; r.malformed = 0;
    r.rate = RATE_UNITY;
    r.dur  = ONE_BEAT_Q16;
    if (p < n && scan_num(n, p + 1, DIV_SAT, mag, neg, e) && !neg && mag != 0)
      r.dur = DUR_W'(262144 / mag);

    if ((c0 == "x" || c0 == "X" || c0 == "1") && c1 == 0) begin
      r.kind = KIND_HIT;
      return r;
    end
    if (c0 == "~" && c1 == 0) return r;

    if ((c0 == "d" || c0 == "D") && is_dig(c1)) begin
      // a digit after d always means a scale degree
      deg = 0; shift = 0; i = 1;
      while (is_dig(char_at(i, p))) begin
        deg = deg * 10 + char_at(i, p) - "0";
        if (deg > NUM_SAT) deg = NUM_SAT;
        i++;
      end
      while (char_at(i, p) == "^" || char_at(i, p) == "_") begin
        shift += char_at(i, p) == "^" ? 1 : -1;
        i++;
      end
      if (char_at(i, p) == 0 && deg >= 1 && deg <= 7) begin
        case (deg)
          1: offs = 0;
          2: offs = 2;
          3: offs = minor_mode ? 3 : 4;
          4: offs = 5;
          5: offs = 7;
          6: offs = minor_mode ? 8 : 9;
          default: offs = minor_mode ? 10 : 11;
        endcase
        midi = 60 + key_tonic + offs + shift * 12;
        if (midi < 0) begin midi = 0; clamp = 1; end
        if (midi > 127) begin midi = 127; clamp = 1; end
        ok = 1;
      end
    end else if (c0 == "k" || c0 == "K") begin
      if (scan_num(p, 1, NUM_SAT, mag, neg, e) && ends_ok(p, e)) begin
        v = neg ? -mag : mag;
        if (v < 1) begin v = 1; clamp = 1; end
        else if (v > 88) begin v = 88; clamp = 1; end
        midi = 20 + v;
        ok = 1;
      end
    end else if (is_dig(c0) || ((c0 == "-" || c0 == "+") && is_dig(c1))) begin
      if (scan_num(p, 0, NUM_SAT, mag, neg, e) && ends_ok(p, e)) begin
        v = neg ? -mag : mag;
        if (v < 0) begin v = 0; clamp = 1; end
        else if (v > 127) begin v = 127; clamp = 1; end
        midi = v;
        ok = 1;
      end
    end else begin
      lc = (c0 >= "A" && c0 <= "Z") ? c0 + 32 : c0;
      known = 1; base = 0; acc = 0;
      case (lc)
        "c": base = 0;
        "d": base = 2;
        "e": base = 4;
        "f": base = 5;
        "g": base = 7;
        "a": base = 9;
        "b": base = 11;
        default: known = 0;
      endcase
      if (!known) begin
        r.kind = KIND_NONE;
        r.dur  = '0;
        return r;
      end
      i = 1;
      if (c1 == "#" || c1 == "b" || c1 == "B") begin
        acc = c1 == "#" ? 1 : -1;
        i = 2;
      end
      if (is_dig(char_at(i, p)) && scan_num(p, i, NUM_SAT, mag, neg, e)
          && ends_ok(p, e)) begin
        v = mag;
        if (v > 8) begin v = 8; clamp = 1; end
        midi = (v + 1) * 12 + base + acc;
        ok = 1;
      end
    end

    if (!ok) begin
      r.malformed = 1;
      return r;
    end
    r.kind    = KIND_NOTE;
    r.midi    = MIDI_W'(midi);
    r.clamped = clamp;
    r.rate    = pitch_rate(midi);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t ERROR token %0d: %s got %0d expected %0d", $realtime, checked, what, got, want);
    errs++;
  endtask

  note_result_t exp_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      key_tonic  <= 4'd0;
      minor_mode <= 1'b0;
      tok_len    = 0;
      tok_closed = 0;
      expected_notes.delete();
      errs = 0; checked = 0; notes = 0; queued = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'(CFG_KEY)) key_tonic <= cfg_data;
        else if (cfg_index == 1'(CFG_SCALE)) minor_mode <= cfg_data[0];
      end
      if (in_tvalid && in_tready) begin
        // zero char closes the text; overflow chars are dropped
        if (!tok_closed) begin
          if (in_tdata == 8'd0) tok_closed = 1;
          else if (tok_len < TOKEN_MAX) begin
            tok_buf[tok_len] = in_tdata;
            tok_len++;
          end
        end
        if (in_tlast) begin
          expected_notes.push_back(predict_note());
          tok_len    = 0;
          tok_closed = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_notes.size() == 0) begin
          report("unexpected result, kind", out_tuser, -1);
        end else begin
          exp_r = expected_notes.pop_front();
          if (out_tuser !== exp_r.kind) report("kind", out_tuser, exp_r.kind);
          if (out_tdata[6:0] !== exp_r.midi) report("note number", out_tdata[6:0], exp_r.midi);
          if (out_tdata[7] !== exp_r.clamped) report("clamped", out_tdata[7], exp_r.clamped);
          if (out_tdata[8] !== exp_r.malformed)
            report("malformed", out_tdata[8], exp_r.malformed);
          if (out_tdata[27:9] !== exp_r.dur) report("duration_q16", out_tdata[27:9], exp_r.dur);
          if (out_tdata[48:28] !== exp_r.rate) report("rate_q16", out_tdata[48:28], exp_r.rate);
          if (exp_r.kind == KIND_NOTE) notes++;
        end
        checked++;
      end
      queued = expected_notes.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the note token parser; checking lives in ntp_checker.
module testbench;
  import ntp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready;
  logic [55:0] out_tdata;   // [6:0] note number, [7] clamped, [8] malformed,
                            // [27:9] duration_q16, [48:28] rate_q16
  logic [1:0]  out_tuser;   // [1:0] kind
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [3:0]  cfg_data;

  int err_count, pending, tokens_checked, notes_checked;
  int in_gap, out_stall;     // idle odds, in percent
  int chars_sent, tokens_sent;
  byte unsigned tok [$];

  note_token_parser u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ntp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending), .tokens_checked(tokens_checked),
    .notes_checked(notes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall);
  end

  // watchdog: far beyond the slowest legal run, stalls included
  initial begin
    #50_000_000;
    $display("Timeout waiting for the parser");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
  endtask

  // one char item; in_tvalid is left high so back-to-back items need no re-raise
  task automatic put_char(input byte unsigned c, input bit l);
    while ($urandom_range(99) < in_gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_token();
    for (int i = 0; i < tok.size(); i++) put_char(tok[i], i == tok.size() - 1);
    tokens_sent++;
    tok.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_token();
  endtask

  // lets the block finish any token in flight, then sits out its tail latency
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_key(input int key, input bit minor);
    drain();
    write_reg(1'(CFG_KEY), 4'(key));
    write_reg(1'(CFG_SCALE), 4'(minor));
  endtask

  // random token, mostly well formed with random content
  task automatic build_token();
    int sel, n;
    sel = $urandom_range(0, 15);
    case (sel)
      0: add_text($urandom_range(0, 2) == 0 ? "x" : ($urandom_range(0, 1) ? "X" : "1"));
      1: add_text("~");
      2, 3: begin
        add_text($urandom_range(0, 1) ? "d" : "D");
        // mostly legal degrees, sometimes 0, 8, 9 or two digits
        if ($urandom_range(0, 7) == 0) add_text($sformatf("%0d", $urandom_range(0, 99)));
        else add_text($sformatf("%0d", $urandom_range(1, 7)));
        n = $urandom_range(0, 9) == 0 ? $urandom_range(6, 12) : $urandom_range(0, 3);
        repeat (n) add_text($urandom_range(0, 1) ? "^" : "_");
      end
      4, 5: begin
        add_text($urandom_range(0, 1) ? "k" : "K");
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) add_text(" ");
        if ($urandom_range(0, 5) == 0) add_text($urandom_range(0, 1) ? "-" : "+");
        add_text($sformatf("%0d", $urandom_range(0, 9) == 0 ? $urandom_range(0, 5000)
                                                            : $urandom_range(0, 100)));
      end
      6, 7: begin
        if ($urandom_range(0, 4) == 0) add_text($urandom_range(0, 1) ? "-" : "+");
        add_text($sformatf("%0d", $urandom_range(0, 9) == 0 ? $urandom_range(0, 9999)
                                                            : $urandom_range(0, 140)));
      end
      8, 9, 10: begin
        tok.push_back(8'($urandom_range(0, 6) + ($urandom_range(0, 1) ? "a" : "A")));
        case ($urandom_range(0, 3))
          0: add_text("#");
          1: add_text($urandom_range(0, 1) ? "b" : "B");
          default: ;
        endcase
        if ($urandom_range(0, 9) != 0)
          add_text($sformatf("%0d", $urandom_range(0, 9) == 0 ? $urandom_range(0, 99)
                                                              : $urandom_range(0, 9)));
      end
      11: repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(1, 255)));
      12: repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
      13: repeat ($urandom_range(1, 4)) tok.push_back(8'($urandom_range(32, 126)));
      14: begin
        // overlong token, chars past the limit are dropped
        add_text("c4 ");
        repeat ($urandom_range(60, 75)) tok.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 1)) add_text("/8");
      end
      default: tok.push_back(8'($urandom_range(0, 1) ? "h" : "z"));
    endcase
    // trailing junk after a space, or glued on
    case ($urandom_range(0, 19))
      0: add_text(" q!");
      1: tok.push_back(8'($urandom_range(33, 126)));
      2: add_text("\t");
      default: ;
    endcase
    if ($urandom_range(0, 9) < 3) begin
      add_text("/");
      case ($urandom_range(0, 9))
        0: ;
        1: add_text($sformatf(" -%0d", $urandom_range(0, 9)));
        2: add_text($sformatf("%0d", $urandom_range(100000, 99999999)));
        3: add_text("0");
        4: add_text($sformatf(" +%0dz", $urandom_range(1, 64)));
        default: add_text($sformatf("%0d", $urandom_range(1, 32)));
      endcase
    end
    // a zero char ends the text early
    if ($urandom_range(0, 29) == 0)
      tok.insert($urandom_range(0, tok.size()), 8'd0);
  endtask

  task automatic random_phase(input int chars);
    int stop_at;
    stop_at = chars_sent + chars;
    while (chars_sent < stop_at) begin
      build_token();
      send_token();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = 4'd0;
    in_gap     = 11;
    out_stall  = 84;
    chars_sent = 0;
    tokens_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: every token kind, clamps, malformed and odd endings
    set_key(0, 0);
    send_text("x"); send_text("X"); send_text("1"); send_text("~");
    send_text("d1"); send_text("d7^^"); send_text("D3__"); send_text("d8");
    send_text("k0"); send_text("k 88"); send_text("k89"); send_text("K-5");
    send_text("127"); send_text("128"); send_text("-3"); send_text("+5");
    send_text("c4"); send_text("C#9"); send_text("bb0"); send_text("a4/8");
    send_text("h3"); send_text("g4/0"); send_text("e4/ 2x"); send_text("c4x");
    send_text("d1^/99999999");
    add_text("c4"); tok.push_back(8'd0); add_text("zz/2"); send_token();
    set_key(11, 1);
    send_text("d7^^^^^^"); send_text("d1______"); send_text("d6");
    tok.push_back(8'hff); tok.push_back(8'h80); send_token();

    // sender busy, receiver stalling
    random_phase(500);
    set_key(11, 0);
    random_phase(100);

    // now the other way round
    in_gap = 84; out_stall = 11;
    set_key(0, 1);
    random_phase(150);
    // hold the sender until every result is out
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
    random_phase(200);
    set_key($urandom_range(1, 10), $urandom_range(0, 1));
    random_phase(150);

    // no idling at all
    in_gap = 0; out_stall = 0;
    set_key(5, 0);
    random_phase(400);

    drain();
    $display("Run covered %0d tokens in %0d chars, %0d pitched notes, across six key/scale settings",
             tokens_checked, chars_sent, notes_checked);
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ntp_pkg.sv
rtl/ntp_div.sv
rtl/ntp_ctrl.sv
rtl/ntp_dpath.sv
rtl/note_token_parser.sv
dv/ntp_checker.sv
dv/testbench.sv
